[design/fhc_pkg.sv]
// Shared constants and types of the fire heat column update block.
`timescale 1ns / 1ps

package fhc_pkg;

  localparam int FACES  = 4;
  localparam int GRID   = 8;
  localparam int FACE_W = 2;
  localparam int COL_W  = 3;
  localparam int ROW_W  = 3;
  localparam int ADDR_W = FACE_W + COL_W;
  localparam int COLUMNS = FACES * GRID;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COOLING   = 2'd1;

  typedef logic [7:0] heat_t;

  // One classified column job, as it waits in the queue.
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [COL_W-1:0]  column;
    logic [63:0]       cool_random;
    logic [8:0]        divisor;
    logic              spawn;
    heat_t             spark_heat;
    logic [5:0]        gain;
  } job_t;

  // A finished column handed from the back part to the emitter.
  typedef struct packed {
    logic              load;
    logic [FACE_W-1:0] face;
    logic [COL_W-1:0]  column;
    heat_t [GRID-1:0]  heat;
  } column_t;

endpackage

[design/fire_heat_column_update.sv]
// Top level of the fire heat column update block.
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     valid / ready         face, column, cool_random, spawn_random, spark_random
// output    out_valid / out_ready out_face, out_column, out_row, heat, red, green, blue, last
// config    cfg_we                cfg_index, cfg_data (no wait, no read-back)
//
// Each input beat updates one column of eight cells and yields eight output
// beats, top row first, the bottom one marked by last.
// The back part works through a column in order: pop and memory read, load,
// eight remainder steps of the eight cooling lanes, subtract, rise and write.
// It takes the next job only after writing the previous column back, and a
// two-deep queue keeps input ready while the back works, until the queue is full.
// Reset clears the queue, the state machines and the column valid bits, so
// every cell reads as zero until its column is first written back.
// A stalled output holds its beat; the back part waits before writing back
// until the emitter has moved the last row of the previous column to its output.

module fire_heat_column_update (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          valid,
  output logic                          ready,
  input  logic [fhc_pkg::FACE_W-1:0]    face,
  input  logic [fhc_pkg::COL_W-1:0]     column,
  input  logic [63:0]                   cool_random,
  input  logic [7:0]                    spawn_random,
  input  logic [7:0]                    spark_random,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fhc_pkg::FACE_W-1:0]    out_face,
  output logic [fhc_pkg::COL_W-1:0]     out_column,
  output logic [fhc_pkg::ROW_W-1:0]     out_row,
  output logic [7:0]                    heat,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [fhc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  fhc_pkg::heat_t   intensity;
  fhc_pkg::heat_t   cooling;
  logic             job_valid;
  logic             pop;
  fhc_pkg::job_t    job;
  fhc_pkg::column_t to_emit;
  logic             emit_busy;

  // Configuration registers. Writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      intensity <= 8'd128;
      cooling   <= 8'd55;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fhc_pkg::REG_INTENSITY: intensity <= cfg_data;
        fhc_pkg::REG_COOLING:   cooling   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front works out the spawn decision, the spark heat, the bottom gain
  // and the cooling divisor once per beat, so the back sees a ready job.
  fhc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .ready        (ready),
    .face         (face),
    .column       (column),
    .cool_random  (cool_random),
    .spawn_random (spawn_random),
    .spark_random (spark_random),
    .intensity    (intensity),
    .cooling      (cooling),
    .pop          (pop),
    .job_valid    (job_valid),
    .job          (job)
  );

  // The back owns the heat memory, one 64-bit word per column.
  fhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .emit_busy (emit_busy),
    .to_emit   (to_emit)
  );

  // The emitter turns each stored column into eight colored pixel beats.
  fhc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .col_in     (to_emit),
    .busy       (emit_busy),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_face   (out_face),
    .out_column (out_column),
    .out_row    (out_row),
    .heat       (heat),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .last       (last)
  );

endmodule

[design/fhc_front.sv]
// Front part: accepts column beats, classifies them and queues the jobs.
`timescale 1ns / 1ps

module fhc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       ready,
  input  logic [fhc_pkg::FACE_W-1:0] face,
  input  logic [fhc_pkg::COL_W-1:0]  column,
  input  logic [63:0]                cool_random,
  input  logic [7:0]                 spawn_random,
  input  logic [7:0]                 spark_random,
  input  fhc_pkg::heat_t             intensity,
  input  fhc_pkg::heat_t             cooling,
  input  logic                       pop,
  output logic                       job_valid,
  output fhc_pkg::job_t              job
);

  fhc_pkg::job_t classified;
  fhc_pkg::job_t slot [2];
  logic [8:0]    threshold;
  logic [15:0]   gain_prod;
  logic          push;
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  // Spawn threshold is intensity/2 + 30; the bottom gain intensity/6 is a
  // reciprocal multiply, exact for every 8-bit intensity.
  always_comb begin
    threshold              = {2'b00, intensity[7:1]} + 9'd30;
    gain_prod              = 16'(intensity) * 16'd171;
    classified.face        = face;
    classified.column      = column;
    classified.cool_random = cool_random;
    classified.divisor     = {1'b0, cooling} + 9'd2;
    classified.spawn       = ({1'b0, spawn_random} < threshold);
    classified.spark_heat  = 8'd160 + (spark_random & 8'h5F);
    classified.gain        = gain_prod[15:10];
  end

  assign ready     = (count != 2'd2);
  assign push      = valid && ready;
  assign job_valid = (count != 2'd0);
  assign job       = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= classified;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 2'd0)
    else $error("queue popped while empty");

endmodule

[design/fhc_back.sv]
// Back part: heat memory, eight-lane cooling remainder, rise and spark update.
`timescale 1ns / 1ps

module fhc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  fhc_pkg::job_t    job,
  output logic             pop,
  input  logic             emit_busy,
  output fhc_pkg::column_t to_emit
);

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_COOL, S_SUB, S_RISE} state_t;

  state_t                          state;
  fhc_pkg::job_t                   work;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] mem [fhc_pkg::COLUMNS];
  logic [fhc_pkg::COLUMNS-1:0]     written;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] rd_data;
  logic                            rd_valid;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] col_heat;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] cooled;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] risen;
  logic [8:0]                      rem      [fhc_pkg::GRID];
  logic [8:0]                      rem_next [fhc_pkg::GRID];
  logic [2:0]                      step;
  logic [fhc_pkg::ADDR_W-1:0]      rd_addr;
  logic [fhc_pkg::ADDR_W-1:0]      wr_addr;
  logic                            wr_en;
  logic                            rem_ok;

  function automatic fhc_pkg::heat_t div3(input logic [9:0] s);
    logic [19:0] p;
    p = 20'(s) * 20'd683;
    return p[18:11];
  endfunction

  assign pop     = (state == S_IDLE) && job_valid;
  assign rd_addr = {job.face, job.column};
  assign wr_addr = {work.face, work.column};
  assign wr_en   = (state == S_RISE) && !emit_busy;

  // One restoring-remainder step per lane and cycle, most significant bit first.
  always_comb begin
    logic [7:0] rb;
    logic [9:0] shifted;
    rem_ok = 1'b1;
    for (int y = 0; y < fhc_pkg::GRID; y++) begin
      rb      = work.cool_random[8*(y%8) +: 8];
      shifted = {rem[y], rb[3'd7 - step]};
      if (shifted >= {1'b0, work.divisor}) begin
        rem_next[y] = 9'(shifted - {1'b0, work.divisor});
      end else begin
        rem_next[y] = shifted[8:0];
      end
      if (rem[y] >= work.divisor) begin
        rem_ok = 1'b0;
      end
      if ({1'b0, col_heat[y]} > rem[y]) begin
        cooled[y] = col_heat[y] - rem[y][7:0];
      end else begin
        cooled[y] = 8'd0;
      end
    end
  end

  // Rise from the cooled column, then spark or gain at the bottom.
  always_comb begin
    logic [9:0] sum;
    logic [8:0] bottom;
    int         y2;
    for (int y = 0; y < fhc_pkg::GRID - 1; y++) begin
      y2       = (y + 2 < fhc_pkg::GRID) ? y + 2 : fhc_pkg::GRID - 1;
      sum      = {2'b00, col_heat[y+1]} + {1'b0, col_heat[y2], 1'b0};
      risen[y] = div3(sum);
    end
    bottom = {1'b0, col_heat[fhc_pkg::GRID-1]} + 9'(work.gain);
    if (work.spawn) begin
      risen[fhc_pkg::GRID-1] = work.spark_heat;
    end else if (bottom[8]) begin
      risen[fhc_pkg::GRID-1] = 8'hFF;
    end else begin
      risen[fhc_pkg::GRID-1] = bottom[7:0];
    end
  end

  assign to_emit.load   = wr_en;
  assign to_emit.face   = work.face;
  assign to_emit.column = work.column;
  assign to_emit.heat   = risen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          step  <= 3'd0;
          state <= S_COOL;
        end
        S_COOL: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= S_SUB;
          end
        end
        S_SUB: begin
          state <= S_RISE;
        end
        S_RISE: begin
          if (!emit_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      work <= job;
    end
    if (state == S_LOAD) begin
      col_heat <= rd_valid ? rd_data : '0;
      rem      <= '{default: '0};
    end
    if (state == S_COOL) begin
      rem <= rem_next;
    end
    if (state == S_SUB) begin
      col_heat <= cooled;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= risen;
    end
    if (pop) begin
      rd_data  <= mem[rd_addr];
      rd_valid <= written[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  a_rem_done: assert property (@(posedge clk) disable iff (rst) (state == S_SUB) |-> rem_ok)
    else $error("cooling remainder not below divisor");
  a_write_free: assert property (@(posedge clk) disable iff (rst) wr_en |-> !emit_busy)
    else $error("column written back while emitter still busy");

endmodule

[design/fhc_emit.sv]
// Emitter: column buffer, palette and output register, one pixel beat a cycle while the output is not stalled.
`timescale 1ns / 1ps

module fhc_emit (
  input  logic                       clk,
  input  logic                       rst,
  input  fhc_pkg::column_t           col_in,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [fhc_pkg::FACE_W-1:0] out_face,
  output logic [fhc_pkg::COL_W-1:0]  out_column,
  output logic [fhc_pkg::ROW_W-1:0]  out_row,
  output fhc_pkg::heat_t             heat,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic                       last
);

  logic [fhc_pkg::FACE_W-1:0]         face_q;
  logic [fhc_pkg::COL_W-1:0]          column_q;
  fhc_pkg::heat_t [fhc_pkg::GRID-1:0] heats;
  logic [fhc_pkg::ROW_W-1:0]          row;
  logic                               advance;
  fhc_pkg::heat_t                     t;
  logic [7:0]                         r;
  logic [7:0]                         g;
  logic [7:0]                         b;

  function automatic logic [7:0] triple(input logic [7:0] x);
    logic [9:0] p;
    p = {2'b00, x} + {1'b0, x, 1'b0};
    return p[7:0];
  endfunction

  assign advance = busy && (!out_valid || out_ready);
  assign t       = heats[row];

  // Black, red, yellow, white in three bands split at 85 and 170.
  always_comb begin
    if (t < 8'd85) begin
      r = triple(t);
      g = 8'd0;
      b = 8'd0;
    end else if (t < 8'd170) begin
      r = 8'd255;
      g = triple(t - 8'd85);
      b = 8'd0;
    end else begin
      r = 8'd255;
      g = 8'd255;
      b = triple(t - 8'd170);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      row       <= '0;
    end else begin
      if (col_in.load) begin
        busy <= 1'b1;
        row  <= '0;
      end else if (advance) begin
        row <= row + 1'b1;
        if (row == fhc_pkg::ROW_W'(fhc_pkg::GRID - 1)) begin
          busy <= 1'b0;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_in.load) begin
      face_q   <= col_in.face;
      column_q <= col_in.column;
      heats    <= col_in.heat;
    end
    if (advance) begin
      out_face   <= face_q;
      out_column <= column_q;
      out_row    <= row;
      heat       <= t;
      red        <= r;
      green      <= g;
      blue       <= b;
      last       <= (row == fhc_pkg::ROW_W'(fhc_pkg::GRID - 1));
    end
  end

endmodule

[tb/tb.sv]
// Self-checking testbench for the fire heat column update block.
`timescale 1ns / 1ps

// The testbench mirrors the block's heat store and both registers. It drives
// column updates on the input channel and predicts the eight cells of each
// accepted update, top row first. A checker compares every output beat,
// field by field, with the oldest predicted cell. Both sides idle at random,
// and one test holds the output off long enough that the input stalls.
module tb;
  import fhc_pkg::*;

  // Register indexes the block does not implement. Writes to these must
  // leave both registers alone.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [7:0] RESET_INTENSITY = 8'd128;
  localparam logic [7:0] RESET_COOLING   = 8'd55;

  // Fire constants: spark heat, spawn threshold bias, bottom-row gain divisor
  // and the palette band limits.
  localparam int SPARK_BASE   = 160;
  localparam int SPARK_MASK   = 'h5F;
  localparam int SPAWN_BIAS   = 30;
  localparam int GAIN_DIVISOR = 6;
  localparam int RED_LIMIT    = 85;
  localparam int YELLOW_LIMIT = 170;
  localparam int FULL_HEAT    = 255;

  localparam int IDLE_PERCENT    = 7;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int TAIL_CYCLES     = 40;
  localparam int CYCLE_LIMIT     = 100000;

  // One reported cell, as it is expected on the output channel.
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    heat_t             heat;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic              last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic valid;
  logic ready;
  logic [FACE_W-1:0] face;
  logic [COL_W-1:0] column;
  logic [63:0] cool_random;
  logic [7:0] spawn_random;
  logic [7:0] spark_random;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [FACE_W-1:0] out_face;
  logic [COL_W-1:0] out_column;
  logic [ROW_W-1:0] out_row;
  logic [7:0] heat;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic last;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0] cfg_data;

  // Mirror of the block's state and registers.
  heat_t heat_mirror [FACES*GRID*GRID];
  logic [7:0] mirror_intensity;
  logic [7:0] mirror_cooling;

  // Cells predicted but not yet seen on the output, oldest first.
  pixel_t pending_pixels [$];

  int error_count = 0;
  int columns_sent = 0;
  int pixels_checked = 0;
  int config_writes = 0;
  int cycle_count = 0;

  // Idling switches, and a request counter for a long output hold-off. Only
  // the stimulus process writes these.
  bit sender_idles;
  bit receiver_idles;
  int hold_off_orders = 0;

  // Hot column that about half of the random updates revisit, so that heat
  // builds up instead of being cooled away in a single pass.
  logic [FACE_W-1:0] hot_face;
  logic [COL_W-1:0] hot_column;

  fire_heat_column_update dut (
    .clk          (clk),
    .rst          (rst),
    .valid        (valid),
    .ready        (ready),
    .face         (face),
    .column       (column),
    .cool_random  (cool_random),
    .spawn_random (spawn_random),
    .spark_random (spark_random),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_face     (out_face),
    .out_column   (out_column),
    .out_row      (out_row),
    .heat         (heat),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .last         (last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Black-red-yellow-white palette: red ramps up first, then green, then blue.
  function automatic void heat_to_color(input int t, output logic [7:0] r,
                                        output logic [7:0] g, output logic [7:0] b);
    if (t < RED_LIMIT) begin
      r = 8'(t * 3);
      g = 8'd0;
      b = 8'd0;
    end else if (t < YELLOW_LIMIT) begin
      r = 8'(FULL_HEAT);
      g = 8'((t - RED_LIMIT) * 3);
      b = 8'd0;
    end else begin
      r = 8'(FULL_HEAT);
      g = 8'(FULL_HEAT);
      b = 8'((t - YELLOW_LIMIT) * 3);
    end
  endfunction

  // Updates the mirrored column for one accepted beat and queues the eight
  // cells the block must report for it.
  function automatic void predict_column_update(input logic [FACE_W-1:0] f,
                                                input logic [COL_W-1:0] col,
                                                input logic [63:0] cool,
                                                input logic [7:0] spawn,
                                                input logic [7:0] spark);
    int base;
    int divisor;
    int cooled [GRID];
    int h;
    int loss;
    int y;
    int y2;
    pixel_t px;
    base = ((int'(f) % FACES) * GRID + int'(col) % GRID) * GRID;
    divisor = int'(mirror_cooling) + 2;
    // Cooling pass: each row loses its random byte modulo the divisor.
    for (y = 0; y < GRID; y++) begin
      loss = int'(cool[(y % 8) * 8 +: 8]) % divisor;
      h = int'(heat_mirror[base + y]);
      cooled[y] = (h > loss) ? h - loss : 0;
    end
    // Rising pass, always taken from the cooled values.
    for (y = 0; y < GRID - 1; y++) begin
      y2 = (y + 2 < GRID) ? y + 2 : GRID - 1;
      heat_mirror[base + y] = heat_t'((cooled[y + 1] + 2 * cooled[y2]) / 3);
    end
    // Bottom row: either a fresh spark or a saturating heat gain.
    if (int'(spawn) < int'(mirror_intensity) / 2 + SPAWN_BIAS) begin
      heat_mirror[base + GRID - 1] = heat_t'(SPARK_BASE + (int'(spark) & SPARK_MASK));
    end else begin
      h = cooled[GRID - 1] + int'(mirror_intensity) / GAIN_DIVISOR;
      heat_mirror[base + GRID - 1] = heat_t'((h > FULL_HEAT) ? FULL_HEAT : h);
    end
    for (y = 0; y < GRID; y++) begin
      px.face = FACE_W'(int'(f) % FACES);
      px.column = COL_W'(int'(col) % GRID);
      px.row = ROW_W'(y);
      px.heat = heat_mirror[base + y];
      heat_to_color(int'(px.heat), px.red, px.green, px.blue);
      px.last = (y == GRID - 1);
      pending_pixels.push_back(px);
    end
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [7:0] data);
    case (idx)
      REG_INTENSITY: mirror_intensity = data;
      REG_COOLING: mirror_cooling = data;
      default: ;
    endcase
  endfunction

  // Sends one column beat. It is entered at a falling edge and returns at the
  // falling edge after acceptance, with valid still high so that a following
  // beat can go out back to back.
  task automatic send_column(input logic [FACE_W-1:0] f, input logic [COL_W-1:0] col,
                             input logic [63:0] cool, input logic [7:0] spawn,
                             input logic [7:0] spark);
    while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
      valid = 1'b0;
      @(negedge clk);
    end
    valid = 1'b1;
    face = f;
    column = col;
    cool_random = cool;
    spawn_random = spawn;
    spark_random = spark;
    do @(posedge clk); while (!ready);
    predict_column_update(f, col, cool, spawn, spark);
    columns_sent++;
    @(negedge clk);
  endtask

  // Random column beat. Some beats get gentle cooling bytes so the store
  // keeps enough heat to reach every palette band.
  task automatic send_random_column();
    logic [FACE_W-1:0] f;
    logic [COL_W-1:0] col;
    logic [63:0] cool;
    if ($urandom_range(1) == 0) begin
      f = hot_face;
      col = hot_column;
    end else begin
      f = FACE_W'($urandom_range(FACES - 1));
      col = COL_W'($urandom_range(GRID - 1));
    end
    cool = {$urandom, $urandom};
    if ($urandom_range(3) == 0) begin
      cool = cool & 64'h0F0F_0F0F_0F0F_0F0F;
    end
    send_column(f, col, cool, 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Stops offering beats and waits until every predicted cell has arrived.
  // Each beat always yields cells, so the block is idle at that point.
  task automatic wait_idle();
    valid = 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    apply_register(idx, data);
    config_writes++;
  endtask

  // Reset registers on a cleared store: a spark on an empty column, the
  // intensity gain on top of it, the spawn threshold on both sides, and the
  // extremes of every input field.
  task automatic test_reset_values();
    send_column(2'd0, 3'd0, 64'd0, 8'd0, 8'd0);
    send_column(2'd0, 3'd0, 64'd0, 8'd255, 8'd0);
    send_column(2'd3, 3'd7, {64{1'b1}}, 8'd255, 8'd255);
    send_column(2'd3, 3'd7, {64{1'b1}}, 8'd0, 8'd255);
    // The spawn threshold with reset intensity is 94.
    send_column(2'd2, 3'd5, 64'h0102_0304_0506_0708, 8'd93, 8'hA0);
    send_column(2'd1, 3'd2, 64'h8070_6050_4030_2010, 8'd94, 8'h5F);
    wait_idle();
  endtask

  // Register extremes. Full intensity with no cooling lets the bottom row
  // gain heat on every pass until it saturates at full heat.
  task automatic test_register_extremes();
    int k;
    write_register(REG_INTENSITY, 8'd255);
    write_register(REG_COOLING, 8'd0);
    for (k = 0; k < 7; k++) begin
      send_column(2'd1, 3'd3, 64'd0, 8'd255, 8'd0);
    end
    send_column(2'd1, 3'd3, {64{1'b1}}, 8'd255, 8'd0);
    wait_idle();
    // No intensity: threshold at its floor and no bottom gain. Widest divisor.
    write_register(REG_INTENSITY, 8'd0);
    write_register(REG_COOLING, 8'd255);
    send_column(2'd1, 3'd3, {64{1'b1}}, 8'd29, 8'h5F);
    send_column(2'd1, 3'd3, 64'hFEFD_0100_8081_7F40, 8'd30, 8'hFF);
    wait_idle();
    // Writes to unknown indexes must not touch either register.
    write_register(REG_SPARE_A, 8'hA5);
    write_register(REG_SPARE_B, 8'h5A);
    send_column(2'd1, 3'd3, {$urandom, $urandom}, 8'd30, 8'd0);
    send_column(2'd0, 3'd6, 64'd0, 8'd29, 8'hE1);
    wait_idle();
  endtask

  // One register setting followed by a run of random column beats.
  task automatic test_random_phase(input int count, input logic [7:0] intens,
                                   input logic [7:0] cool_cfg);
    int k;
    wait_idle();
    write_register(REG_INTENSITY, intens);
    write_register(REG_COOLING, cool_cfg);
    hot_face = FACE_W'($urandom_range(FACES - 1));
    hot_column = COL_W'($urandom_range(GRID - 1));
    for (k = 0; k < count; k++) begin
      send_random_column();
    end
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so the
  // input queue fills and ready drops until the output drains.
  task automatic test_output_backpressure();
    int k;
    wait_idle();
    sender_idles = 1'b0;
    hold_off_orders++;
    for (k = 0; k < 30; k++) begin
      send_random_column();
    end
    wait_idle();
    sender_idles = 1'b1;
  endtask

  // Receiver: random stalls, plus the long hold-off when one is requested.
  always @(negedge clk) begin : drive_out_ready
    static int hold_left = 0;
    static int hold_off_served = 0;
    if (hold_off_served != hold_off_orders) begin
      hold_off_served = hold_off_orders;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = !(receiver_idles && $urandom_range(99) < IDLE_PERCENT);
    end
  end

  task automatic compare_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Every accepted output beat is matched against the oldest predicted cell.
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        $display("%0t ns: output beat with nothing expected, actual face %0d column %0d row %0d",
                 $time, out_face, out_column, out_row);
        error_count++;
      end else begin
        want = pending_pixels.pop_front();
        compare_field("out_face", 8'(want.face), 8'(out_face));
        compare_field("out_column", 8'(want.column), 8'(out_column));
        compare_field("out_row", 8'(want.row), 8'(out_row));
        compare_field("heat", want.heat, heat);
        compare_field("red", want.red, red);
        compare_field("green", want.green, green);
        compare_field("blue", want.blue, blue);
        compare_field("last", 8'(want.last), 8'(last));
        pixels_checked++;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Cycle limit reached with %0d cells still expected", pending_pixels.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    valid = 1'b0;
    face = '0;
    column = '0;
    cool_random = '0;
    spawn_random = '0;
    spark_random = '0;
    cfg_we = 1'b0;
    cfg_index = REG_INTENSITY;
    cfg_data = '0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hot_face = '0;
    hot_column = '0;
    mirror_intensity = RESET_INTENSITY;
    mirror_cooling = RESET_COOLING;
    foreach (heat_mirror[i]) heat_mirror[i] = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_register_extremes();
    test_random_phase(60, 8'($urandom_range(255)), 8'($urandom_range(255)));
    // A long stretch with no idling on either side.
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_phase(50, RESET_INTENSITY, RESET_COOLING);
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    test_random_phase(40, 8'd0, 8'd0);
    test_random_phase(40, 8'd255, 8'd255);
    test_output_backpressure();
    test_random_phase(40, 8'($urandom_range(255)), 8'($urandom_range(63)));

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Ran %0d column updates and checked %0d cells over %0d register writes,",
             columns_sent, pixels_checked, config_writes);
    $display("covering register extremes, spawn threshold edges, heat saturation and a %0d-cycle output stall.",
             HOLD_OFF_CYCLES);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
